/* rtl/core/assert_macros.svh */
// Concurrent assertion macros shared by the RTL.
// Define SYNTH to compile them away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    `ASSERT_CLK(lbl, clk, rstn, !(cond))
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* rtl/core/rmq_pkg.sv */
// Shared constants and types for the rotation matrix to quaternion pipeline.
// No dependencies.
`default_nettype none
package rmq_pkg;
    localparam int DATA_WIDTH_DEF = 16;

    typedef struct packed {
        logic vld;
        logic bad;
    } rmq_ctl_t;
endpackage
`default_nettype wire

/* rtl/core/rotation_matrix_to_quaternion.sv */
// Rotation matrix (signed Q1.F, F = DATA_WIDTH-2) to unit quaternion, fully pipelined:
// one branch/term stage, DATA_WIDTH square root stages, DATA_WIDTH+1 divider stages
// in four parallel lanes. A new matrix is taken every cycle while the output is not
// stalled; the square root and the quotient are each formed one bit per stage.
// A stalled output freezes the whole pipeline. Depends on rmq_pkg, rmq_front,
// rmq_sqrt, rmq_div and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [DATA_WIDTH-1:0]  s_r00,
    input  wire logic signed [DATA_WIDTH-1:0]  s_r01,
    input  wire logic signed [DATA_WIDTH-1:0]  s_r02,
    input  wire logic signed [DATA_WIDTH-1:0]  s_r10,
    input  wire logic signed [DATA_WIDTH-1:0]  s_r11,
    input  wire logic signed [DATA_WIDTH-1:0]  s_r12,
    input  wire logic signed [DATA_WIDTH-1:0]  s_r20,
    input  wire logic signed [DATA_WIDTH-1:0]  s_r21,
    input  wire logic signed [DATA_WIDTH-1:0]  s_r22,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [DATA_WIDTH-1:0]       m_qx,
    output logic signed [DATA_WIDTH-1:0]       m_qy,
    output logic signed [DATA_WIDTH-1:0]       m_qz,
    output logic signed [DATA_WIDTH-1:0]       m_qw,
    output logic                               m_bad_pivot
);
    localparam int TW = DATA_WIDTH + 2;
    localparam int PW = 4 * TW + 4;

    logic                         en;
    rmq_pkg::rmq_ctl_t            fr_ctl, sq_ctl;
    logic [3:0][TW-1:0]           fr_mag, sq_mag;
    logic [3:0]                   fr_neg, sq_neg;
    logic [2*DATA_WIDTH-1:0]      fr_rad;
    logic [DATA_WIDTH-1:0]        sq_root;
    logic [PW-1:0]                sq_pay;
    rmq_pkg::rmq_ctl_t            lane_ctl [4];
    logic signed [DATA_WIDTH-1:0] lane_q   [4];

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    rmq_front #(.W(DATA_WIDTH)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .s_valid (s_valid),
        .r00     (s_r00), .r01 (s_r01), .r02 (s_r02),
        .r10     (s_r10), .r11 (s_r11), .r12 (s_r12),
        .r20     (s_r20), .r21 (s_r21), .r22 (s_r22),
        .ctl_o   (fr_ctl),
        .mag_o   (fr_mag),
        .neg_o   (fr_neg),
        .rad_o   (fr_rad)
    );

    rmq_sqrt #(.W(DATA_WIDTH), .PW(PW)) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_i   (fr_ctl),
        .rad_i   (fr_rad),
        .pay_i   ({fr_neg, fr_mag}),
        .ctl_o   (sq_ctl),
        .root_o  (sq_root),
        .pay_o   (sq_pay)
    );

    assign sq_neg = sq_pay[PW-1 -: 4];
    assign sq_mag = sq_pay[4*TW-1:0];

    for (genvar i = 0; i < 4; i++) begin : g_lane
        rmq_div #(.W(DATA_WIDTH)) u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_i   (sq_ctl),
            .mag_i   (sq_mag[i]),
            .neg_i   (sq_neg[i]),
            .s_i     (sq_root),
            .ctl_o   (lane_ctl[i]),
            .q_o     (lane_q[i])
        );
    end

    assign m_valid     = lane_ctl[0].vld;
    assign m_bad_pivot = lane_ctl[0].bad;
    assign m_qx        = lane_q[0];
    assign m_qy        = lane_q[1];
    assign m_qz        = lane_q[2];
    assign m_qw        = lane_q[3];

    `ASSERT_CLK(a_bad_zero, aclk, aresetn, (m_valid && m_bad_pivot) |-> (m_qx == '0 && m_qy == '0 && m_qz == '0 && m_qw == '0))
    `ASSERT_NEVER(a_lane_sync, aclk, aresetn, (lane_ctl[0] != lane_ctl[1]) || (lane_ctl[0] != lane_ctl[2]) || (lane_ctl[0] != lane_ctl[3]))
    `ASSERT_CLK(a_stall_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_qw) && $stable(m_bad_pivot)))
endmodule
`default_nettype wire

/* rtl/core/rmq_front.sv */
// Branch selection, unnormalized quaternion terms and pivot check.
// Depends on rmq_pkg.
`default_nettype none
module rmq_front #(
    parameter int W = rmq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    s_valid,
    input  wire logic signed [W-1:0]     r00, r01, r02,
    input  wire logic signed [W-1:0]     r10, r11, r12,
    input  wire logic signed [W-1:0]     r20, r21, r22,
    output rmq_pkg::rmq_ctl_t            ctl_o,
    output logic [3:0][W+1:0]            mag_o,
    output logic [3:0]                   neg_o,
    output logic [2*W-1:0]               rad_o
);
    localparam int TW = W + 2;
    localparam int F  = W - 2;
    localparam logic signed [TW-1:0] ONE = TW'(1 << F);

    logic signed [TW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [TW-1:0] t [4];
    logic signed [TW-1:0] piv;
    logic                 bad;
    logic signed [TW-1:0] sum01;

    rmq_pkg::rmq_ctl_t    ctl_reg;
    logic [3:0][TW-1:0]   mag_reg, mag_next;
    logic [3:0]           neg_reg, neg_next;
    logic [2*W-1:0]       rad_reg, rad_next;

    assign e00 = TW'(r00);
    assign e01 = TW'(r01);
    assign e02 = TW'(r02);
    assign e10 = TW'(r10);
    assign e11 = TW'(r11);
    assign e12 = TW'(r12);
    assign e20 = TW'(r20);
    assign e21 = TW'(r21);
    assign e22 = TW'(r22);
    assign sum01 = e00 + e11;

    always_comb begin
        if (e22 < 0) begin
            if (e00 > e11) begin
                t[0] = ONE + e00 - e11 - e22;
                t[1] = e01 + e10;
                t[2] = e20 + e02;
                t[3] = e21 - e12;
                piv  = t[0];
            end else begin
                t[0] = e01 + e10;
                t[1] = ONE - e00 + e11 - e22;
                t[2] = e12 + e21;
                t[3] = e02 - e20;
                piv  = t[1];
            end
        end else begin
            if (sum01 < 0) begin
                t[0] = e20 + e02;
                t[1] = e12 + e21;
                t[2] = ONE - e00 - e11 + e22;
                t[3] = e10 - e01;
                piv  = t[2];
            end else begin
                t[0] = e21 - e12;
                t[1] = e02 - e20;
                t[2] = e10 - e01;
                t[3] = ONE + e00 + e11 + e22;
                piv  = t[3];
            end
        end
        bad = piv[TW-1] || (piv == '0);
        for (int i = 0; i < 4; i++) begin
            neg_next[i] = t[i][TW-1];
            mag_next[i] = t[i][TW-1] ? TW'(-t[i]) : TW'(t[i]);
        end
        rad_next = bad ? '0 : ({{(W-2){1'b0}}, piv} << F);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg.vld <= s_valid;
            ctl_reg.bad <= bad;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
            rad_reg <= rad_next;
        end
    end

    assign ctl_o = ctl_reg;
    assign mag_o = mag_reg;
    assign neg_o = neg_reg;
    assign rad_o = rad_reg;
endmodule
`default_nettype wire

/* rtl/core/rmq_sqrt.sv */
// Pipelined integer square root, one result bit per stage, side payload carried.
// Depends on rmq_pkg.
`default_nettype none
module rmq_sqrt #(
    parameter int W  = rmq_pkg::DATA_WIDTH_DEF,
    parameter int PW = 4 * (rmq_pkg::DATA_WIDTH_DEF + 2) + 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire rmq_pkg::rmq_ctl_t  ctl_i,
    input  wire logic [2*W-1:0]     rad_i,
    input  wire logic [PW-1:0]      pay_i,
    output rmq_pkg::rmq_ctl_t       ctl_o,
    output logic [W-1:0]            root_o,
    output logic [PW-1:0]           pay_o
);
    localparam int RMW = W + 3;

    logic [RMW-1:0]     rem_d  [0:W];
    logic [W-1:0]       root_d [0:W];
    logic [2*W-1:0]     rad_d  [0:W];

    logic [RMW-1:0]     rem_reg  [1:W], rem_next  [1:W];
    logic [W-1:0]       root_reg [1:W], root_next [1:W];
    logic [2*W-1:0]     rad_reg  [1:W], rad_next  [1:W];
    logic [PW-1:0]      pay_reg  [1:W];
    rmq_pkg::rmq_ctl_t  ctl_reg  [1:W];

    logic [RMW-1:0]     rm  [1:W];
    logic [RMW-1:0]     trl [1:W];

    always_comb begin
        rem_d[0]  = '0;
        root_d[0] = '0;
        rad_d[0]  = rad_i;
        for (int j = 1; j <= W; j++) begin
            rem_d[j]  = rem_reg[j];
            root_d[j] = root_reg[j];
            rad_d[j]  = rad_reg[j];
        end
        for (int j = 1; j <= W; j++) begin
            rm[j]  = {rem_d[j-1][RMW-3:0], rad_d[j-1][2*W-1:2*W-2]};
            trl[j] = {1'b0, root_d[j-1], 2'b01};
            if (rm[j] >= trl[j]) begin
                rem_next[j]  = rm[j] - trl[j];
                root_next[j] = {root_d[j-1][W-2:0], 1'b1};
            end else begin
                rem_next[j]  = rm[j];
                root_next[j] = {root_d[j-1][W-2:0], 1'b0};
            end
            rad_next[j] = {rad_d[j-1][2*W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 1; j <= W; j++) begin
                ctl_reg[j] <= '0;
            end
        end else if (en) begin
            ctl_reg[1] <= ctl_i;
            for (int j = 2; j <= W; j++) begin
                ctl_reg[j] <= ctl_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay_reg[1] <= pay_i;
            for (int j = 2; j <= W; j++) begin
                pay_reg[j] <= pay_reg[j-1];
            end
            for (int j = 1; j <= W; j++) begin
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
                rad_reg[j]  <= rad_next[j];
            end
        end
    end

    assign ctl_o  = ctl_reg[W];
    assign root_o = root_reg[W];
    assign pay_o  = pay_reg[W];
endmodule
`default_nettype wire

/* rtl/core/rmq_div.sv */
// One divider lane: rounded |term| * 2^F / (2 s), one quotient bit per stage,
// then sign restore and saturation, or zero on a bad pivot. Depends on rmq_pkg.
`default_nettype none
module rmq_div #(
    parameter int W = rmq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire rmq_pkg::rmq_ctl_t  ctl_i,
    input  wire logic [W+1:0]       mag_i,
    input  wire logic               neg_i,
    input  wire logic [W-1:0]       s_i,
    output rmq_pkg::rmq_ctl_t       ctl_o,
    output logic signed [W-1:0]     q_o
);
    localparam int RW = 2 * W + 1;
    localparam int F  = W - 2;

    logic [RW-1:0]      rem_reg [0:W-1], rem_next [0:W-1];
    logic [W:0]         d_reg   [0:W-1], d_next   [0:W-1];
    logic [W-2:0]       q_reg   [0:W-1], q_next   [0:W-1];
    logic               ovf_reg [0:W-1], ovf_next [0:W-1];
    logic               neg_reg [0:W-1];
    rmq_pkg::rmq_ctl_t  ctl_reg [0:W-1];

    logic [RW-1:0]      dk [1:W-1];

    logic signed [W-1:0] res_reg, res_next;
    rmq_pkg::rmq_ctl_t   ctl_out_reg;

    always_comb begin
        rem_next[0] = RW'({mag_i, {F{1'b0}}}) + RW'(s_i);
        d_next[0]   = {s_i, 1'b0};
        q_next[0]   = '0;
        ovf_next[0] = rem_next[0] >= RW'({s_i, {W{1'b0}}});
        for (int j = 1; j < W; j++) begin
            dk[j]       = {{W{1'b0}}, d_reg[j-1]} << (W - 1 - j);
            d_next[j]   = d_reg[j-1];
            ovf_next[j] = ovf_reg[j-1];
            if (rem_reg[j-1] >= dk[j]) begin
                rem_next[j] = rem_reg[j-1] - dk[j];
                q_next[j]   = q_reg[j-1] | ((W-1)'(1) << (W - 1 - j));
            end else begin
                rem_next[j] = rem_reg[j-1];
                q_next[j]   = q_reg[j-1];
            end
        end
        if (ctl_reg[W-1].bad) begin
            res_next = '0;
        end else if (ovf_reg[W-1]) begin
            res_next = neg_reg[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else if (neg_reg[W-1]) begin
            res_next = -$signed({1'b0, q_reg[W-1]});
        end else begin
            res_next = $signed({1'b0, q_reg[W-1]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < W; j++) begin
                ctl_reg[j] <= '0;
            end
            ctl_out_reg <= '0;
        end else if (en) begin
            ctl_reg[0] <= ctl_i;
            for (int j = 1; j < W; j++) begin
                ctl_reg[j] <= ctl_reg[j-1];
            end
            ctl_out_reg <= ctl_reg[W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg[0] <= neg_i;
            for (int j = 1; j < W; j++) begin
                neg_reg[j] <= neg_reg[j-1];
            end
            for (int j = 0; j < W; j++) begin
                rem_reg[j] <= rem_next[j];
                d_reg[j]   <= d_next[j];
                q_reg[j]   <= q_next[j];
                ovf_reg[j] <= ovf_next[j];
            end
            res_reg <= res_next;
        end
    end

    assign ctl_o = ctl_out_reg;
    assign q_o   = res_reg;
endmodule
`default_nettype wire
